// ===== rtl/vfd_pkg.sv =====
// shared constants and types for the video frame deframer
package vfd_pkg;

   localparam int LENGTH_BITS  = 27;
   localparam int CFG_BITS     = 27;
   localparam int HDR_IDX_BITS = 5;

   localparam logic [31:0] FRAME_MAGIC      = 32'h4f4d_4f46;
   localparam logic [31:0] HARD_MAX_PAYLOAD = 32'h0400_0000;
   localparam logic [31:0] LEN_MASK         = 32'((64'd1 << LENGTH_BITS) - 64'd1);
   localparam int          BPP_SHIFT        = 2;

   localparam logic [HDR_IDX_BITS-1:0] HDR_MAGIC_FIRST  = 5'd0;
   localparam logic [HDR_IDX_BITS-1:0] HDR_MAGIC_LAST   = 5'd3;
   localparam logic [HDR_IDX_BITS-1:0] HDR_WIDTH_FIRST  = 5'd6;
   localparam logic [HDR_IDX_BITS-1:0] HDR_WIDTH_LAST   = 5'd7;
   localparam logic [HDR_IDX_BITS-1:0] HDR_HEIGHT_FIRST = 5'd8;
   localparam logic [HDR_IDX_BITS-1:0] HDR_HEIGHT_LAST  = 5'd9;
   localparam logic [HDR_IDX_BITS-1:0] HDR_STRIDE_FIRST = 5'd12;
   localparam logic [HDR_IDX_BITS-1:0] HDR_STRIDE_LAST  = 5'd15;
   localparam logic [HDR_IDX_BITS-1:0] HDR_ID_FIRST     = 5'd16;
   localparam logic [HDR_IDX_BITS-1:0] HDR_ID_LAST      = 5'd19;
   localparam logic [HDR_IDX_BITS-1:0] HDR_LEN_FIRST    = 5'd20;
   localparam logic [HDR_IDX_BITS-1:0] HDR_LEN_LAST     = 5'd23;
   localparam logic [HDR_IDX_BITS-1:0] HDR_FINAL        = HDR_LEN_LAST;

   localparam logic PHASE_HEADER  = 1'b0;
   localparam logic PHASE_PAYLOAD = 1'b1;

   localparam logic [1:0] ERR_NONE       = 2'd0;
   localparam logic [1:0] ERR_BAD_MAGIC  = 2'd1;
   localparam logic [1:0] ERR_ZERO_DIM   = 2'd2;
   localparam logic [1:0] ERR_BAD_LENGTH = 2'd3;

   localparam logic [CFG_BITS-1:0] CFG_RESET = CFG_BITS'(HARD_MAX_PAYLOAD);

   typedef struct packed {
      logic        payload_valid;
      logic [7:0]  payload_byte;
      logic        last_of_frame;
      logic        header_done;
      logic [15:0] frame_width;
      logic [15:0] frame_height;
      logic [31:0] row_stride;
      logic [31:0] frame_number;
      logic [26:0] payload_length;
      logic        error_flag;
      logic [1:0]  error_code;
   } vfd_result_type;

endpackage

// ===== rtl/vfd_req_if.sv =====
// input byte stream channel
interface vfd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;

   modport source (output valid, output data_byte, input ready);
   modport sink (input valid, input data_byte, output ready);
endinterface

// ===== rtl/vfd_rsp_if.sv =====
// result channel carrying payload bytes and header status
interface vfd_rsp_if;
   logic        valid;
   logic        ready;
   logic        payload_valid;
   logic [7:0]  payload_byte;
   logic        last_of_frame;
   logic        header_done;
   logic [15:0] frame_width;
   logic [15:0] frame_height;
   logic [31:0] row_stride;
   logic [31:0] frame_number;
   logic [26:0] payload_length;
   logic        error_flag;
   logic [1:0]  error_code;

   modport source (
      output valid, output payload_valid, output payload_byte, output last_of_frame,
      output header_done, output frame_width, output frame_height, output row_stride,
      output frame_number, output payload_length, output error_flag, output error_code,
      input ready
   );
   modport sink (
      input valid, input payload_valid, input payload_byte, input last_of_frame,
      input header_done, input frame_width, input frame_height, input row_stride,
      input frame_number, input payload_length, input error_flag, input error_code,
      output ready
   );
endinterface

// ===== rtl/video_frame_deframer_top.sv =====
// video frame deframer: splits a byte stream into checked headers and payload beats
//
// One input beat is taken every clock cycle while the output buffer has room and
// yields exactly one result beat, so the block runs at one byte per cycle unless
// the result channel stalls; the parser works out a byte's result combinationally
// and it lands in a two-entry output buffer, so a new byte is still taken while
// one finished result waits on the result channel. Each result is registered in
// the output buffer before it is offered. The maximum payload length register may
// be written at any time and takes effect at the next header check.
module video_frame_deframer_top import vfd_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   vfd_req_if.sink             req_chan,
   vfd_rsp_if.source           rsp_chan,
   input  logic                csr_write_enable,
   input  logic [CFG_BITS-1:0] csr_write_data
);

   logic           has_room;
   logic           in_accept;
   logic           out_accept;
   vfd_result_type result;
   vfd_result_type head;

   assign req_chan.ready = has_room;
   assign in_accept      = req_chan.valid && has_room;
   assign out_accept     = rsp_chan.valid && rsp_chan.ready;

   vfd_parser u_parser (
      .clock            (clock),
      .reset            (reset),
      .in_accept        (in_accept),
      .in_byte          (req_chan.data_byte),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .result           (result)
   );

   vfd_out_buffer u_out_buffer (
      .clock     (clock),
      .reset     (reset),
      .push      (in_accept),
      .push_data (result),
      .has_room  (has_room),
      .pop       (out_accept),
      .not_empty (rsp_chan.valid),
      .head      (head)
   );

   assign rsp_chan.payload_valid  = head.payload_valid;
   assign rsp_chan.payload_byte   = head.payload_byte;
   assign rsp_chan.last_of_frame  = head.last_of_frame;
   assign rsp_chan.header_done    = head.header_done;
   assign rsp_chan.frame_width    = head.frame_width;
   assign rsp_chan.frame_height   = head.frame_height;
   assign rsp_chan.row_stride     = head.row_stride;
   assign rsp_chan.frame_number   = head.frame_number;
   assign rsp_chan.payload_length = head.payload_length;
   assign rsp_chan.error_flag     = head.error_flag;
   assign rsp_chan.error_code     = head.error_code;

endmodule

// ===== rtl/vfd_parser.sv =====
// header parser and payload tracker, one byte per accepted beat
module vfd_parser import vfd_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_accept,
   input  logic [7:0]          in_byte,
   input  logic                csr_write_enable,
   input  logic [CFG_BITS-1:0] csr_write_data,
   output vfd_result_type      result
);

   logic                   phase_ff, phase_in;
   logic [LENGTH_BITS-1:0] count_ff, count_in, count_plus;
   logic [31:0]            magic_ff, magic_in;
   logic [15:0]            width_ff, width_in;
   logic [15:0]            height_ff, height_in;
   logic [31:0]            stride_ff, stride_in;
   logic [31:0]            id_ff, id_in;
   logic [31:0]            length_ff, length_in;
   logic [CFG_BITS-1:0]    max_len_ff;
   logic [HDR_IDX_BITS-1:0] hdr_idx;
   logic [31:0]            limit_a, limit;
   logic [31:0]            stride_out;
   logic [1:0]             code;

   assign count_plus = count_ff + LENGTH_BITS'(1);
   assign hdr_idx    = count_ff[HDR_IDX_BITS-1:0];

   assign limit_a = (32'(max_len_ff) > HARD_MAX_PAYLOAD) ? HARD_MAX_PAYLOAD : 32'(max_len_ff);
   assign limit   = (limit_a > LEN_MASK) ? LEN_MASK : limit_a;

   assign stride_out = (stride_in != 32'd0) ? stride_in : (32'(width_in) << BPP_SHIFT);

   always_comb begin
      if (magic_in != FRAME_MAGIC) begin
         code = ERR_BAD_MAGIC;
      end else if (width_in == 16'd0 || height_in == 16'd0) begin
         code = ERR_ZERO_DIM;
      end else if (length_in == 32'd0 || length_in > limit) begin
         code = ERR_BAD_LENGTH;
      end else begin
         code = ERR_NONE;
      end
   end

   always_comb begin
      phase_in  = phase_ff;
      count_in  = count_ff;
      magic_in  = magic_ff;
      width_in  = width_ff;
      height_in = height_ff;
      stride_in = stride_ff;
      id_in     = id_ff;
      length_in = length_ff;
      result    = '0;

      if (phase_ff == PHASE_HEADER) begin
         unique case (hdr_idx) inside
            [HDR_MAGIC_FIRST:HDR_MAGIC_LAST]:   magic_in  = {magic_ff[23:0], in_byte};
            [HDR_WIDTH_FIRST:HDR_WIDTH_LAST]:   width_in  = {width_ff[7:0], in_byte};
            [HDR_HEIGHT_FIRST:HDR_HEIGHT_LAST]: height_in = {height_ff[7:0], in_byte};
            [HDR_STRIDE_FIRST:HDR_STRIDE_LAST]: stride_in = {stride_ff[23:0], in_byte};
            [HDR_ID_FIRST:HDR_ID_LAST]:         id_in     = {id_ff[23:0], in_byte};
            [HDR_LEN_FIRST:HDR_LEN_LAST]:       length_in = {length_ff[23:0], in_byte};
            default: ;
         endcase
      end

      if (phase_ff == PHASE_PAYLOAD || hdr_idx == HDR_FINAL) begin
         result.frame_width    = width_in;
         result.frame_height   = height_in;
         result.row_stride     = stride_out;
         result.frame_number   = id_in;
         result.payload_length = 27'(length_in & LEN_MASK);
      end

      if (phase_ff == PHASE_PAYLOAD) begin
         result.payload_valid = 1'b1;
         result.payload_byte  = in_byte;
         if (32'(count_plus) == length_ff) begin
            result.last_of_frame = 1'b1;
            phase_in             = PHASE_HEADER;
            count_in             = '0;
         end else begin
            count_in = count_plus;
         end
      end else if (hdr_idx != HDR_FINAL) begin
         count_in = count_plus;
      end else begin
         count_in = '0;
         if (code != ERR_NONE) begin
            result.error_flag = 1'b1;
            result.error_code = code;
         end else begin
            result.header_done = 1'b1;
            phase_in           = PHASE_PAYLOAD;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PHASE_HEADER;
         count_ff   <= '0;
         max_len_ff <= CFG_RESET;
      end else begin
         if (in_accept) begin
            phase_ff <= phase_in;
            count_ff <= count_in;
         end
         if (csr_write_enable) begin
            max_len_ff <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_accept) begin
         magic_ff  <= magic_in;
         width_ff  <= width_in;
         height_ff <= height_in;
         stride_ff <= stride_in;
         id_ff     <= id_in;
         length_ff <= length_in;
      end
   end

endmodule

// ===== rtl/vfd_out_buffer.sv =====
// two-entry result buffer between parser and result channel
module vfd_out_buffer import vfd_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           push,
   input  vfd_result_type push_data,
   output logic           has_room,
   input  logic           pop,
   output logic           not_empty,
   output vfd_result_type head
);

   logic [1:0]     count_ff, count_in;
   vfd_result_type slot_ff [2];
   vfd_result_type slot0_in, slot1_in;

   assign has_room  = (count_ff != 2'd2);
   assign not_empty = (count_ff != 2'd0);
   assign head      = slot_ff[0];

   always_comb begin
      count_in = count_ff;
      slot0_in = slot_ff[0];
      slot1_in = slot_ff[1];
      if (push && pop) begin
         if (count_ff == 2'd1) begin
            slot0_in = push_data;
         end else begin
            slot0_in = slot_ff[1];
            slot1_in = push_data;
         end
      end else if (push) begin
         count_in = count_ff + 2'd1;
         if (count_ff == 2'd0) begin
            slot0_in = push_data;
         end else begin
            slot1_in = push_data;
         end
      end else if (pop) begin
         count_in = count_ff - 2'd1;
         slot0_in = slot_ff[1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff[0] <= slot0_in;
      slot_ff[1] <= slot1_in;
   end

endmodule

// ===== tb/video_frame_deframer_top_tb.sv =====
// self-checking testbench for the video frame deframer: header parsing, payload beats, errors
module video_frame_deframer_top_tb;
   import vfd_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 200000;
   localparam int SEG_BYTES   = 30;

   typedef struct packed {
      logic                do_cfg;
      logic [CFG_BITS-1:0] cfg;
      logic [31:0]         magic;
      logic [15:0]         w;
      logic [15:0]         h;
      logic [31:0]         stride;
      logic [31:0]         id;
      logic [31:0]         len;
      logic                typed;
      logic [1:0]          code;
   } frame_row_type;

   typedef struct packed {
      logic       typed;
      logic [1:0] code;
   } typed_code_type;

   typedef struct {
      vfd_result_type res;
      logic           typed;
      logic [1:0]     code;
   } beat_entry_type;

   logic clock;
   logic reset;
   logic                csr_write_enable;
   logic [CFG_BITS-1:0] csr_write_data;

   vfd_req_if req_chan ();
   vfd_rsp_if rsp_chan ();

   video_frame_deframer_top dut (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_chan),
      .rsp_chan         (rsp_chan),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   // deframer state as the block should hold it
   logic                   parse_phase  = PHASE_HEADER;
   logic [LENGTH_BITS-1:0] parse_count  = '0;
   logic [31:0]            hdr_magic    = '0;
   logic [15:0]            hdr_width    = '0;
   logic [15:0]            hdr_height   = '0;
   logic [31:0]            hdr_stride   = '0;
   logic [31:0]            hdr_frame_id = '0;
   logic [31:0]            hdr_length   = '0;
   logic [CFG_BITS-1:0]    max_length   = CFG_RESET;

   beat_entry_type pending_results[$];
   typed_code_type header_codes[$];

   int fail_count    = 0;
   int cycle_count   = 0;
   int sent_bytes    = 0;
   int send_idle_pct = 27;
   int recv_idle_pct = 88;

   frame_row_type frame_table [16] = '{
      '{1'b0, CFG_RESET, FRAME_MAGIC, 16'd1, 16'd1, 32'd0, 32'd0, 32'd1, 1'b1, ERR_NONE},
      '{1'b0, CFG_RESET, FRAME_MAGIC, 16'hffff, 16'hffff, 32'd0, 32'hffff_ffff, 32'd3,
        1'b1, ERR_NONE},
      '{1'b0, CFG_RESET, FRAME_MAGIC, 16'd640, 16'd480, 32'hffff_ffff, 32'd7, 32'd2,
        1'b0, ERR_NONE},
      '{1'b0, CFG_RESET, 32'h4f4d_4f47, 16'd0, 16'd5, 32'd0, 32'd1, 32'd4, 1'b1, ERR_BAD_MAGIC},
      '{1'b0, CFG_RESET, 32'd0, 16'd1, 16'd1, 32'd0, 32'd1, 32'd1, 1'b1, ERR_BAD_MAGIC},
      '{1'b0, CFG_RESET, FRAME_MAGIC, 16'd0, 16'd1, 32'd0, 32'd0, 32'd0, 1'b1, ERR_ZERO_DIM},
      '{1'b0, CFG_RESET, FRAME_MAGIC, 16'd1, 16'd0, 32'd0, 32'd0, 32'd1, 1'b1, ERR_ZERO_DIM},
      '{1'b0, CFG_RESET, FRAME_MAGIC, 16'd3, 16'd3, 32'd0, 32'd0, 32'd0, 1'b1, ERR_BAD_LENGTH},
      '{1'b0, CFG_RESET, FRAME_MAGIC, 16'd3, 16'd3, 32'd0, 32'd0, 32'hffff_ffff,
        1'b1, ERR_BAD_LENGTH},
      '{1'b1, 27'h7ff_ffff, FRAME_MAGIC, 16'd2, 16'd2, 32'd0, 32'd9, 32'h0400_0001,
        1'b1, ERR_BAD_LENGTH},
      '{1'b1, 27'd5, FRAME_MAGIC, 16'd4, 16'd2, 32'd16, 32'd10, 32'd5, 1'b1, ERR_NONE},
      '{1'b0, 27'd5, FRAME_MAGIC, 16'd4, 16'd2, 32'd16, 32'd11, 32'd6, 1'b1, ERR_BAD_LENGTH},
      '{1'b1, 27'd1, FRAME_MAGIC, 16'd1, 16'd1, 32'd0, 32'd12, 32'd1, 1'b1, ERR_NONE},
      '{1'b0, 27'd1, FRAME_MAGIC, 16'd1, 16'd1, 32'd0, 32'd13, 32'd2, 1'b1, ERR_BAD_LENGTH},
      '{1'b1, 27'd0, FRAME_MAGIC, 16'd1, 16'd1, 32'd0, 32'd14, 32'd1, 1'b1, ERR_BAD_LENGTH},
      '{1'b1, CFG_RESET, FRAME_MAGIC, 16'd2, 16'd2, 32'h10, 32'd15, 32'd4, 1'b0, ERR_NONE}
   };

   initial clock = 1'b0;
   always #10 clock = ~clock;

   function automatic logic [31:0] length_limit();
      logic [31:0] lim;
      lim = 32'(max_length);
      if (lim > HARD_MAX_PAYLOAD) lim = HARD_MAX_PAYLOAD;
      if (lim > LEN_MASK) lim = LEN_MASK;
      return lim;
   endfunction

   function automatic vfd_result_type with_header(input vfd_result_type r);
      vfd_result_type o;
      o = r;
      o.frame_width    = hdr_width;
      o.frame_height   = hdr_height;
      o.row_stride     = (hdr_stride != 0) ? hdr_stride : (32'(hdr_width) << BPP_SHIFT);
      o.frame_number   = hdr_frame_id;
      o.payload_length = hdr_length[LENGTH_BITS-1:0];
      return o;
   endfunction

   function automatic vfd_result_type deframe_byte(input logic [7:0] b);
      vfd_result_type         r;
      logic [LENGTH_BITS-1:0] next_count;
      logic [HDR_IDX_BITS-1:0] idx;
      logic [1:0]             code;
      r = '0;
      if (parse_phase == PHASE_PAYLOAD) begin
         next_count = parse_count + 1'b1;
         r.payload_valid = 1'b1;
         r.payload_byte = b;
         r = with_header(r);
         if (32'(next_count) == hdr_length) begin
            r.last_of_frame = 1'b1;
            parse_phase = PHASE_HEADER;
            parse_count = '0;
         end else begin
            parse_count = next_count;
         end
         return r;
      end
      idx = parse_count[HDR_IDX_BITS-1:0];
      if (idx <= HDR_MAGIC_LAST)
         hdr_magic = {hdr_magic[23:0], b};
      else if (idx >= HDR_WIDTH_FIRST && idx <= HDR_WIDTH_LAST)
         hdr_width = {hdr_width[7:0], b};
      else if (idx >= HDR_HEIGHT_FIRST && idx <= HDR_HEIGHT_LAST)
         hdr_height = {hdr_height[7:0], b};
      else if (idx >= HDR_STRIDE_FIRST && idx <= HDR_STRIDE_LAST)
         hdr_stride = {hdr_stride[23:0], b};
      else if (idx >= HDR_ID_FIRST && idx <= HDR_ID_LAST)
         hdr_frame_id = {hdr_frame_id[23:0], b};
      else if (idx >= HDR_LEN_FIRST && idx <= HDR_LEN_LAST)
         hdr_length = {hdr_length[23:0], b};
      if (idx != HDR_FINAL) begin
         parse_count = parse_count + 1'b1;
         return r;
      end
      code = ERR_NONE;
      if (hdr_magic != FRAME_MAGIC)
         code = ERR_BAD_MAGIC;
      else if (hdr_width == 0 || hdr_height == 0)
         code = ERR_ZERO_DIM;
      else if (hdr_length == 0 || hdr_length > length_limit())
         code = ERR_BAD_LENGTH;
      r = with_header(r);
      parse_count = '0;
      if (code != ERR_NONE) begin
         r.error_flag = 1'b1;
         r.error_code = code;
         parse_phase = PHASE_HEADER;
      end else begin
         r.header_done = 1'b1;
         parse_phase = PHASE_PAYLOAD;
      end
      return r;
   endfunction

   function automatic void check_field(input string name, input logic [31:0] exp_v,
                                       input logic [31:0] act_v);
      if (act_v !== exp_v) begin
         $display("%0t %s expected %0h actual %0h", $time, name, exp_v, act_v);
         fail_count++;
      end
   endfunction

   always @(posedge clock) begin : accept_blk
      beat_entry_type ent;
      typed_code_type tc;
      if (!reset && req_chan.valid && req_chan.ready) begin
         ent.res = deframe_byte(req_chan.data_byte);
         ent.typed = 1'b0;
         ent.code = ERR_NONE;
         if ((ent.res.header_done || ent.res.error_flag) && header_codes.size() > 0) begin
            tc = header_codes.pop_front();
            ent.typed = tc.typed;
            ent.code = tc.code;
         end
         pending_results.push_back(ent);
      end
   end

   always @(posedge clock) begin : check_blk
      beat_entry_type ent;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (pending_results.size() == 0) begin
            $display("%0t unexpected result beat, payload_byte %0h", $time,
                     rsp_chan.payload_byte);
            fail_count++;
         end else begin
            ent = pending_results.pop_front();
            check_field("payload_valid", 32'(ent.res.payload_valid),
                        32'(rsp_chan.payload_valid));
            check_field("payload_byte", 32'(ent.res.payload_byte),
                        32'(rsp_chan.payload_byte));
            check_field("last_of_frame", 32'(ent.res.last_of_frame),
                        32'(rsp_chan.last_of_frame));
            check_field("header_done", 32'(ent.res.header_done),
                        32'(rsp_chan.header_done));
            check_field("frame_width", 32'(ent.res.frame_width),
                        32'(rsp_chan.frame_width));
            check_field("frame_height", 32'(ent.res.frame_height),
                        32'(rsp_chan.frame_height));
            check_field("row_stride", ent.res.row_stride, rsp_chan.row_stride);
            check_field("frame_number", ent.res.frame_number, rsp_chan.frame_number);
            check_field("payload_length", 32'(ent.res.payload_length),
                        32'(rsp_chan.payload_length));
            check_field("error_flag", 32'(ent.res.error_flag), 32'(rsp_chan.error_flag));
            check_field("error_code", 32'(ent.res.error_code), 32'(rsp_chan.error_code));
            if (ent.typed)
               check_field("header error_code", 32'(ent.code), 32'(rsp_chan.error_code));
         end
      end
   end

   always @(posedge clock)
      rsp_chan.ready <= ($urandom_range(99) >= recv_idle_pct);

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("video_frame_deframer_top: mismatch");
         $finish;
      end
   end

   task automatic send_byte(input logic [7:0] b);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.data_byte <= b;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      sent_bytes++;
   endtask

   task automatic drain_results();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_max(input logic [CFG_BITS-1:0] value);
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      max_length = value;
      csr_write_enable <= 1'b0;
   endtask

   task automatic send_frame(input logic [31:0] magic, input logic [15:0] w,
                             input logic [15:0] h, input logic [31:0] stride,
                             input logic [31:0] id, input logic [31:0] len,
                             input int n_payload);
      logic [191:0] hdr;
      hdr = {magic, 16'($urandom), w, h, 16'($urandom), stride, id, len};
      for (int i = 0; i < 24; i++)
         send_byte(hdr[191-8*i -: 8]);
      for (int i = 0; i < n_payload; i++)
         send_byte(8'($urandom));
   endtask

   task automatic send_random_frame();
      int          kind;
      int          n;
      int          nz;
      logic [31:0] lim;
      logic [31:0] magic;
      logic [31:0] stride;
      logic [31:0] len;
      logic [15:0] w;
      logic [15:0] h;
      kind = $urandom_range(99);
      magic = FRAME_MAGIC;
      w = ($urandom_range(9) == 0) ? 16'hffff : 16'($urandom_range(1, 65535));
      h = ($urandom_range(9) == 0) ? 16'hffff : 16'($urandom_range(1, 65535));
      stride = $urandom_range(1) ? 32'd0 : 32'($urandom);
      lim = length_limit();
      n = 0;
      if (kind < 75 && lim != 0) begin
         len = $urandom_range(1, (lim < 20) ? lim : 20);
         n = len;
      end else begin
         len = $urandom;
         case ($urandom_range(4))
            0: magic = magic ^ (32'd1 << $urandom_range(31));
            1: w = '0;
            2: h = '0;
            3: len = $urandom_range(1) ? 32'd0 : lim + 32'd1 + $urandom_range(1000);
            default: begin
               nz = 24 * $urandom_range(1, 2);
               for (int i = 0; i < nz; i++)
                  send_byte(8'($urandom));
               return;
            end
         endcase
      end
      send_frame(magic, w, h, stride, $urandom, len, n);
   endtask

   initial begin : stim_blk
      frame_row_type row;
      int            seg_start;
      req_chan.valid <= 1'b0;
      req_chan.data_byte <= '0;
      csr_write_enable <= 1'b0;
      csr_write_data <= '0;
      reset <= 1'b1;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < $size(frame_table); i++) begin
         row = frame_table[i];
         if (row.do_cfg) begin
            drain_results();
            write_max(row.cfg);
         end
         header_codes.push_back({row.typed, row.code});
         send_frame(row.magic, row.w, row.h, row.stride, row.id, row.len,
                    (row.code == ERR_NONE) ? int'(row.len) : 0);
      end

      for (int seg = 0; seg < 3; seg++) begin
         drain_results();
         case (seg)
            0: write_max(CFG_BITS'($urandom_range(1, 30)));
            1: write_max(27'h7ff_ffff);
            default: write_max(CFG_BITS'($urandom));
         endcase
         send_idle_pct = (seg == 0) ? 27 : (seg == 1) ? 88 : 0;
         recv_idle_pct = (seg == 0) ? 88 : (seg == 1) ? 27 : 0;
         seg_start = sent_bytes;
         while (sent_bytes - seg_start < SEG_BYTES)
            send_random_frame();
      end

      drain_results();
      repeat (8) @(posedge clock);
      if (pending_results.size() != 0) begin
         $display("%0t %0d result beats never arrived", $time, pending_results.size());
         fail_count++;
      end
      if (fail_count == 0)
         $display("video_frame_deframer_top: match");
      else
         $display("video_frame_deframer_top: mismatch");
      $finish;
   end

endmodule

// ===== video_frame_deframer_top.f =====
rtl/vfd_pkg.sv
rtl/vfd_req_if.sv
rtl/vfd_rsp_if.sv
rtl/vfd_parser.sv
rtl/vfd_out_buffer.sv
rtl/video_frame_deframer_top.sv
tb/video_frame_deframer_top_tb.sv
